@@ rtl/kli_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe linear interpolator package
// Shared widths, codes and payload types of the interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

	// Field widths
	localparam int TIME_W  = 24;
	localparam int COMP_W  = 32;
	localparam int VAL_W   = 4 * COMP_W;
	localparam int INST_W  = 10;
	localparam int SLOT_W  = 4;
	localparam int SEG_W   = 4;
	localparam int CNT_W   = 5;
	localparam int SPAN    = 16;

	// Interpolation arithmetic widths
	localparam int DIFF_W  = COMP_W + 1;
	localparam int NUM_W   = TIME_W + 1;
	localparam int PROD_W  = DIFF_W + NUM_W;

	// Item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	// Configuration register indexes
	localparam logic CFG_ENABLE    = 1'b0;
	localparam logic CFG_KEY_COUNT = 1'b1;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;

endpackage
`default_nettype wire

@@ rtl/kli_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module kli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/kli_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module kli_div #(
	parameter int N_W = 58,
	parameter int D_W = 25
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic signed [N_W-1:0] dividend,
	input  wire logic signed [D_W-1:0] divisor,
	output logic                       done,
	output logic signed [N_W-1:0]      quotient
);

	localparam int CW = $clog2(N_W);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [N_W-1:0] dvd_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] dvs_q;
	logic           neg_q;
	logic [D_W:0]   rem_sh;
	logic [D_W+1:0] diff;

	// Trial subtraction for the current bit.
	always_comb begin
		rem_sh = {rem_q, dvd_q[N_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand magnitudes and the shifting quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[N_W-1] ? N_W'(-dividend) : N_W'(dividend);
			dvs_q <= divisor[D_W-1] ? D_W'(-divisor) : D_W'(divisor);
			rem_q <= '0;
			neg_q <= dividend[N_W-1] ^ divisor[D_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[N_W-2:0], ~diff[D_W+1]};
			rem_q <= diff[D_W+1] ? rem_sh[D_W-1:0] : diff[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule
`default_nettype wire

@@ rtl/keyframe_linear_interpolator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Load items write the key tables and give no result.
// An evaluate item at the last key skips the serial divide; otherwise the serial divide
// dominates its time, and every segment walk step adds to it.
// Each walk step requests one key time from the key time memory and then checks it.
// One item is in work at a time; the output register lets the next item enter.
// After reset the instance cache is cleared, one entry a cycle.
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Keyframe tables and per-instance segment cache in RAMs, with a segment walk
// sequencer and four serial dividers for the interpolation ratio.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit #(
	parameter int MAX_KEYS      = 16,
	parameter int MAX_INSTANCES = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [kli_pkg::CNT_W-1:0]     cfg_data,
	// Input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic [kli_pkg::INST_W-1:0]    instance_id,
	input  wire logic [kli_pkg::SLOT_W-1:0]    key_slot,
	input  wire logic [kli_pkg::TIME_W-1:0]    time_value,
	input  wire logic signed [kli_pkg::COMP_W-1:0] comp_x,
	input  wire logic signed [kli_pkg::COMP_W-1:0] comp_y,
	input  wire logic signed [kli_pkg::COMP_W-1:0] comp_z,
	input  wire logic signed [kli_pkg::COMP_W-1:0] comp_w,
	// Output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [kli_pkg::INST_W-1:0]         out_instance,
	output logic signed [kli_pkg::COMP_W-1:0]  out_x,
	output logic signed [kli_pkg::COMP_W-1:0]  out_y,
	output logic signed [kli_pkg::COMP_W-1:0]  out_z,
	output logic signed [kli_pkg::COMP_W-1:0]  out_w,
	output logic [kli_pkg::SEG_W-1:0]          segment_index,
	output logic                               at_last_key
);

	localparam int KEYS   = (MAX_KEYS < kli_pkg::SPAN) ? MAX_KEYS : kli_pkg::SPAN;
	localparam int KW     = $clog2(KEYS);
	localparam int IDEPTH = (MAX_INSTANCES < 1024) ? MAX_INSTANCES : 1024;
	localparam int IW     = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
	localparam int PW     = kli_pkg::PROD_W;
	localparam int NW     = kli_pkg::NUM_W;
	localparam int TW     = kli_pkg::TIME_W;
	localparam int SW     = kli_pkg::SEG_W;

	typedef enum logic [13:0] {
		ST_CLEAR   = 14'b00000000000001,
		ST_IDLE    = 14'b00000000000010,
		ST_CACHE   = 14'b00000000000100,
		ST_FWD_REQ = 14'b00000000001000,
		ST_FWD_CHK = 14'b00000000010000,
		ST_BWD_REQ = 14'b00000000100000,
		ST_BWD_CHK = 14'b00000001000000,
		ST_FETCH_A = 14'b00000010000000,
		ST_FETCH_B = 14'b00000100000000,
		ST_LATCH_B = 14'b00001000000000,
		ST_MUL     = 14'b00010000000000,
		ST_DIV_GO  = 14'b00100000000000,
		ST_DIV     = 14'b01000000000000,
		ST_SUM     = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic                      enable_q;
	logic [kli_pkg::CNT_W-1:0] key_count_q;
	logic [kli_pkg::CNT_W-1:0] n_keys;
	logic [kli_pkg::CNT_W-1:0] n_last;
	logic [IW-1:0]             clr_cnt_q;
	logic                      in_accept;
	logic                      eval_ok;
	logic                      pending_q;

	logic [kli_pkg::INST_W-1:0] inst_q;
	logic [TW-1:0]              tval_q;
	logic [SW-1:0]              idx_q;
	logic                       last_q;
	logic                       last_w;
	logic [TW-1:0]              t0_q;
	logic [TW-1:0]              t1_q;
	logic signed [NW-1:0]       den_q;
	kli_pkg::comp_t             a_q   [4];
	kli_pkg::comp_t             b_q   [4];
	kli_pkg::comp_t             res_q [4];
	kli_pkg::prod_t             prod_q [4];
	kli_pkg::prod_t             quot   [4];
	logic [3:0]                 div_done;
	logic                       div_start;
	logic                       out_free;

	// Memory ports
	logic [KW-1:0]               key_raddr;
	logic [TW-1:0]               time_rd;
	logic [kli_pkg::VAL_W-1:0]   value_rd;
	logic                        key_we;
	logic                        cache_we;
	logic [IW-1:0]               cache_waddr;
	logic [SW-1:0]               cache_wdata;
	logic [SW-1:0]               cache_rd;

	// Saturate a wide sum to the signed 32-bit range.
	function automatic kli_pkg::comp_t sat32(input logic signed [PW:0] s);
		kli_pkg::comp_t r;
		if (!s[PW] && (|s[PW-1:kli_pkg::COMP_W-1])) begin
			r = {1'b0, {(kli_pkg::COMP_W-1){1'b1}}};
		end else if (s[PW] && !(&s[PW-1:kli_pkg::COMP_W-1])) begin
			r = {1'b1, {(kli_pkg::COMP_W-1){1'b0}}};
		end else begin
			r = s[kli_pkg::COMP_W-1:0];
		end
		return r;
	endfunction

	// Keys in use and handshake decode.
	always_comb begin
		n_keys    = (key_count_q > kli_pkg::CNT_W'(KEYS)) ? kli_pkg::CNT_W'(KEYS)
			: key_count_q;
		n_last    = n_keys - 1'b1;
		in_stall  = (state_q != ST_IDLE);
		in_accept = in_valid && !in_stall;
		eval_ok   = enable_q && (n_keys != '0)
			&& ({7'd0, instance_id} < 17'(IDEPTH));
		last_w    = ({1'b0, idx_q} >= n_last);
		out_free  = !pending_q || !out_stall;
		cfg_ready = 1'b1;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			key_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kli_pkg::CFG_ENABLE:    enable_q    <= cfg_data[0];
				kli_pkg::CFG_KEY_COUNT: key_count_q <= cfg_data;
				default:                enable_q    <= enable_q;
			endcase
		end
	end

	// Key table read address follows the sequencer state.
	always_comb begin
		case (state_q)
			ST_FWD_REQ: key_raddr = KW'(idx_q + 1'b1);
			ST_BWD_REQ: key_raddr = KW'(idx_q);
			ST_FETCH_A: key_raddr = last_w ? KW'(n_last) : KW'(idx_q);
			ST_FETCH_B: key_raddr = KW'(idx_q + 1'b1);
			default:    key_raddr = KW'(idx_q);
		endcase
		key_we      = in_accept && (mode == kli_pkg::MODE_LOAD)
			&& ({1'b0, key_slot} < 5'(KEYS));
		cache_we    = (state_q == ST_CLEAR) || (state_q == ST_FETCH_A);
		cache_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : IW'(inst_q);
		cache_wdata = (state_q == ST_CLEAR) ? '0 : idx_q;
		div_start   = (state_q == ST_DIV_GO) && (den_q != '0);
	end

	kli_ram #(.WIDTH(TW), .DEPTH(KEYS)) u_time_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (KW'(key_slot)),
		.wdata (time_value),
		.re    (1'b1),
		.raddr (key_raddr),
		.rdata (time_rd)
	);

	kli_ram #(.WIDTH(kli_pkg::VAL_W), .DEPTH(KEYS)) u_value_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (KW'(key_slot)),
		.wdata ({comp_w, comp_z, comp_y, comp_x}),
		.re    (1'b1),
		.raddr (key_raddr),
		.rdata (value_rd)
	);

	kli_ram #(.WIDTH(SW), .DEPTH(IDEPTH)) u_cache_ram (
		.clk   (clk),
		.we    (cache_we),
		.waddr (cache_waddr),
		.wdata (cache_wdata),
		.re    (in_accept),
		.raddr (IW'(instance_id)),
		.rdata (cache_rd)
	);

	// One serial divider per component.
	for (genvar c = 0; c < 4; c++) begin : g_div
		kli_div #(.N_W(PW), .D_W(NW)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (prod_q[c]),
			.divisor  (den_q),
			.done     (div_done[c]),
			.quotient (quot[c])
		);
	end

	// Sequencer: clearing pass, segment walk, fetch, blend and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			pending_q <= 1'b0;
		end else begin
			// The result word is held until the output side takes it.
			if ((state_q == ST_SUM) && out_free) begin
				pending_q <= 1'b1;
			end else if (pending_q && !out_stall) begin
				pending_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IW'(IDEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept && (mode == kli_pkg::MODE_EVAL) && eval_ok) begin
						state_q <= ST_CACHE;
					end
				end
				ST_CACHE:   state_q <= ST_FWD_REQ;
				ST_FWD_REQ: state_q <= ({1'b0, idx_q} < n_last) ? ST_FWD_CHK : ST_BWD_REQ;
				ST_FWD_CHK: state_q <= (time_rd < tval_q) ? ST_FWD_REQ : ST_BWD_REQ;
				ST_BWD_REQ: state_q <= (idx_q != '0) ? ST_BWD_CHK : ST_FETCH_A;
				ST_BWD_CHK: state_q <= (time_rd > tval_q) ? ST_BWD_REQ : ST_FETCH_A;
				ST_FETCH_A: state_q <= ST_FETCH_B;
				ST_FETCH_B: state_q <= last_q ? ST_SUM : ST_LATCH_B;
				ST_LATCH_B: state_q <= ST_MUL;
				ST_MUL:     state_q <= ST_DIV_GO;
				ST_DIV_GO:  state_q <= (den_q != '0) ? ST_DIV : ST_SUM;
				ST_DIV: begin
					if (div_done[0]) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the item in work.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				inst_q <= instance_id;
				tval_q <= time_value;
			end
			ST_CACHE: begin
				idx_q <= ({1'b0, cache_rd} > n_last) ? SW'(n_last) : cache_rd;
			end
			ST_FWD_CHK: begin
				if (time_rd < tval_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_BWD_CHK: begin
				if (time_rd > tval_q) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			ST_FETCH_A: begin
				last_q <= last_w;
			end
			ST_FETCH_B: begin
				t0_q <= time_rd;
				for (int c = 0; c < 4; c++) begin
					a_q[c]   <= value_rd[c*kli_pkg::COMP_W +: kli_pkg::COMP_W];
					res_q[c] <= value_rd[c*kli_pkg::COMP_W +: kli_pkg::COMP_W];
				end
			end
			ST_LATCH_B: begin
				t1_q <= time_rd;
				for (int c = 0; c < 4; c++) begin
					b_q[c] <= value_rd[c*kli_pkg::COMP_W +: kli_pkg::COMP_W];
				end
			end
			ST_MUL: begin
				den_q <= $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
				for (int c = 0; c < 4; c++) begin
					prod_q[c] <= ($signed({b_q[c][kli_pkg::COMP_W-1], b_q[c]})
						- $signed({a_q[c][kli_pkg::COMP_W-1], a_q[c]}))
						* ($signed({1'b0, tval_q}) - $signed({1'b0, t0_q}));
				end
			end
			ST_DIV: begin
				if (div_done[0]) begin
					for (int c = 0; c < 4; c++) begin
						res_q[c] <= sat32($signed({{(PW-kli_pkg::COMP_W+1){a_q[c][
							kli_pkg::COMP_W-1]}}, a_q[c]}) + $signed({quot[c][PW-1],
							quot[c]}));
					end
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if ((state_q == ST_SUM) && out_free) begin
			out_instance  <= inst_q;
			out_x         <= res_q[0];
			out_y         <= res_q[1];
			out_z         <= res_q[2];
			out_w         <= res_q[3];
			segment_index <= idx_q;
			at_last_key   <= last_q;
		end
	end

	assign out_valid = pending_q;

endmodule
`default_nettype wire

@@ rtl/kli_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe interpolator port checker
// Port-level properties of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module kli_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic signed [kli_pkg::COMP_W-1:0]   out_x,
	input wire logic [kli_pkg::INST_W-1:0]          out_instance
);

	// A stalled result word stays valid and holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_instance))
		else $error("stalled result word changed");

	// The input side stalls when reset is released, while the instance cache is cleared.
	a_clear_stall: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> in_stall)
		else $error("input accepted during cache clearing");

	// No result word appears right after a word is accepted.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

	// When a result word rises, no word was accepted in the cycle before.
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && !in_stall))
		else $error("result rose without work in progress");

endmodule

bind keyframe_linear_interpolator_unit kli_checker u_kli_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_x        (out_x),
	.out_instance (out_instance)
);
`default_nettype wire
